@@ src/drcm_pkg.sv @@
// Shared types, codes and defaults for the descriptor ratio cross-check matcher.
package drcm_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int MAX_DIMS_DEF   = 128;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_MATCH  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RATIO  = 2'd1,
        ST_XFAIL  = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNT_A      = 3'd0,
        CFG_COUNT_B      = 3'd1,
        CFG_DIMS_USED    = 3'd2,
        CFG_RATIO_EN     = 3'd3,
        CFG_CROSS_EN     = 3'd4,
        CFG_RATIO_NUM    = 3'd5,
        CFG_RATIO_DEN    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_cmd        cmd;
        logic [9:0]  row;
        logic [6:0]  col;
        logic [7:0]  value;
    } t_in_item;

    typedef struct packed {
        logic [9:0]  query_index;
        logic [9:0]  partner_index;
        t_status     status;
        logic [22:0] nearest_dist_sq;
    } t_out_item;

endpackage

@@ src/descriptor_ratio_crosscheck_match_unit.sv @@
// Top level: descriptor stores, distance pipeline and match sequencer.
//
//  channel   | signals                          | direction | role
//  ----------+----------------------------------+-----------+-----------------------------
//  in        | i_in_valid, o_in_ready, i_in     | input     | load element or match query
//  out       | o_out_valid, i_out_ready, o_out  | output    | one result per match query
//  cfg       | i_cfg_valid, o_cfg_ready,        | input     | register writes, always ready
//            | i_cfg_index, i_cfg_data          |           |
//
// A load writes its element straight into its store. A match scans set B, then set A when the
// cross-check runs: one element pair per cycle through the single read port of each store and
// one square-accumulate unit; the ratio test shares one multiplier over four steps.
// Synchronous active-low reset clears control and presets configuration, not the stores.
// The input is not ready while a query runs; a finished result waits in the output register.
module descriptor_ratio_crosscheck_match_unit #(
    parameter int MAX_POINTS = drcm_pkg::MAX_POINTS_DEF,
    parameter int MAX_DIMS   = drcm_pkg::MAX_DIMS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  drcm_pkg::t_in_item                 i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output drcm_pkg::t_out_item                o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [drcm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [drcm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import drcm_pkg::*;

    localparam int PIW       = $clog2(MAX_POINTS);
    localparam int KW        = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CW        = $clog2(MAX_POINTS + 1);
    localparam int DW        = $clog2(MAX_DIMS + 1);
    localparam int MEM_DEPTH = MAX_POINTS * MAX_DIMS;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int DSW       = $clog2(MAX_DIMS * 65025 + 1);
    localparam int PW        = DSW + 16;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_SCANB  = 12'b0000_0000_0010,
        S_WAITB  = 12'b0000_0000_0100,
        S_MULDEN = 12'b0000_0000_1000,
        S_MULNUM = 12'b0000_0001_0000,
        S_MULL   = 12'b0000_0010_0000,
        S_MULR   = 12'b0000_0100_0000,
        S_CMP    = 12'b0000_1000_0000,
        S_SCANA  = 12'b0001_0000_0000,
        S_WAITA  = 12'b0010_0000_0000,
        S_XRES   = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    t_status n_status, r_status;

    // configuration
    logic [10:0] r_count_a, r_count_b;
    logic [7:0]  r_dims, r_ratio_num, r_ratio_den;
    logic        r_ratio_en, r_cross_en;

    // stores
    logic [7:0] r_mem_a [MEM_DEPTH];
    logic [7:0] r_mem_b [MEM_DEPTH];

    // sequencer
    logic [PIW-1:0] r_q, r_i, r_nlast, r_best, r_aidx;
    logic [KW-1:0]  r_k, r_klast;
    logic [CW-1:0]  r_na;
    logic [DSW-1:0] r_d1, r_d2, r_amin;
    logic           r_have2;
    logic [15:0]    r_den2, r_num2;
    logic [PW-1:0]  r_lhs, r_rhs;

    // distance pipeline
    logic           r_s1_v, r_s1_first, r_s1_last, r_s1_final;
    logic [PIW-1:0] r_s1_row;
    logic [7:0]     r_rd_a, r_rd_b;
    logic           r_s2_v, r_s2_first, r_s2_last, r_s2_final;
    logic [PIW-1:0] r_s2_row;
    logic [15:0]    r_sq;
    logic [DSW-1:0] r_acc;
    logic           r_done_v, r_done_final;
    logic [PIW-1:0] r_drow;
    logic [DSW-1:0] r_dist;

    logic           r_out_v;
    t_out_item      r_out;

    logic           in_fire, cfg_fire, load_ok, row_ok, is_match, issue, last_issue;
    logic           phase_a, out_free;
    logic [CW-1:0]  eff_na, eff_nb;
    logic [DW-1:0]  eff_dims;
    logic [AW-1:0]  waddr, addr_a, addr_b;
    logic [PIW-1:0] idx_a, idx_b;
    logic signed [8:0]  w_diff;
    logic signed [17:0] w_sq;
    logic [DSW-1:0] w_sum;
    logic [DSW-1:0] mul_x;
    logic [15:0]    mul_y;
    logic [PW-1:0]  mul_p;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    assign in_fire  = i_in_valid && o_in_ready;
    assign cfg_fire = i_cfg_valid && o_cfg_ready;
    assign load_ok  = (32'(i_in.row) < 32'(MAX_POINTS)) && (32'(i_in.col) < 32'(MAX_DIMS));
    assign row_ok   = (32'(i_in.row) < 32'(MAX_POINTS));
    assign is_match = in_fire && (i_in.cmd == CMD_MATCH) && row_ok;
    assign out_free = !r_out_v || i_out_ready;

    assign eff_na = (32'(r_count_a) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(r_count_a);
    assign eff_nb = (32'(r_count_b) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(r_count_b);
    assign eff_dims = (r_dims == 8'd0) ? DW'(1) :
                      (32'(r_dims) > 32'(MAX_DIMS)) ? DW'(MAX_DIMS) : DW'(r_dims);

    assign issue      = (r_state == S_SCANB) || (r_state == S_SCANA);
    assign last_issue = (r_k == r_klast) && (r_i == r_nlast);
    assign phase_a    = (r_state == S_SCANA) || (r_state == S_WAITA);

    assign waddr  = AW'(AW'(i_in.row) * AW'(MAX_DIMS) + AW'(i_in.col));
    assign idx_a  = (r_state == S_SCANA) ? r_i : r_q;
    assign idx_b  = (r_state == S_SCANA) ? r_best : r_i;
    assign addr_a = AW'(AW'(idx_a) * AW'(MAX_DIMS) + AW'(r_k));
    assign addr_b = AW'(AW'(idx_b) * AW'(MAX_DIMS) + AW'(r_k));

    assign w_diff = $signed({1'b0, r_rd_a}) - $signed({1'b0, r_rd_b});
    assign w_sq   = w_diff * w_diff;
    assign w_sum  = (r_s2_first ? '0 : r_acc) + DSW'(r_sq);

    // shared multiplier for the ratio test
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        unique case (r_state)
            S_MULDEN: begin mul_x = DSW'(r_ratio_den); mul_y = 16'(r_ratio_den); end
            S_MULNUM: begin mul_x = DSW'(r_ratio_num); mul_y = 16'(r_ratio_num); end
            S_MULL:   begin mul_x = r_d1; mul_y = r_den2; end
            S_MULR:   begin mul_x = r_d2; mul_y = r_num2; end
            default:  begin mul_x = '0; mul_y = '0; end
        endcase
    end
    assign mul_p = PW'(mul_x) * PW'(mul_y);

    always_comb begin
        n_state  = r_state;
        n_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (is_match) begin
                    if (eff_nb == '0) begin
                        n_state  = S_OUT;
                        n_status = ST_EMPTY;
                    end else begin
                        n_state = S_SCANB;
                    end
                end
            end
            S_SCANB: if (last_issue) n_state = S_WAITB;
            S_WAITB: if (r_done_v && r_done_final) n_state = S_MULDEN;
            S_MULDEN, S_CMP: begin
                if ((r_state == S_MULDEN) && r_ratio_en && r_have2) begin
                    n_state = S_MULNUM;
                end else if ((r_state == S_CMP) && (r_lhs > r_rhs)) begin
                    n_state  = S_OUT;
                    n_status = ST_RATIO;
                end else if (!r_cross_en) begin
                    n_state = S_OUT;
                end else if (r_na == '0) begin
                    n_state  = S_OUT;
                    n_status = ST_XFAIL;
                end else begin
                    n_state = S_SCANA;
                end
            end
            S_MULNUM: n_state = S_MULL;
            S_MULL:   n_state = S_MULR;
            S_MULR:   n_state = S_CMP;
            S_SCANA:  if (last_issue) n_state = S_WAITA;
            S_WAITA:  if (r_done_v && r_done_final) n_state = S_XRES;
            S_XRES: begin
                n_state  = S_OUT;
                n_status = (r_aidx == r_q) ? ST_OK : ST_XFAIL;
            end
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // stores: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (in_fire && (i_in.cmd == CMD_LOAD_A) && load_ok) begin
            r_mem_a[waddr] <= i_in.value;
        end
        r_rd_a <= r_mem_a[addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (i_in.cmd == CMD_LOAD_B) && load_ok) begin
            r_mem_b[waddr] <= i_in.value;
        end
        r_rd_b <= r_mem_b[addr_b];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_a   <= '0;
            r_count_b   <= '0;
            r_dims      <= 8'd128;
            r_ratio_en  <= 1'b1;
            r_cross_en  <= 1'b1;
            r_ratio_num <= 8'd2;
            r_ratio_den <= 8'd5;
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                CFG_COUNT_A:   r_count_a   <= i_cfg_data;
                CFG_COUNT_B:   r_count_b   <= i_cfg_data;
                CFG_DIMS_USED: r_dims      <= i_cfg_data[7:0];
                CFG_RATIO_EN:  r_ratio_en  <= i_cfg_data[0];
                CFG_CROSS_EN:  r_cross_en  <= i_cfg_data[0];
                CFG_RATIO_NUM: r_ratio_num <= i_cfg_data[7:0];
                CFG_RATIO_DEN: r_ratio_den <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // distance pipeline: read, square, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_done_v <= 1'b0;
        end else begin
            r_s1_v   <= issue;
            r_s2_v   <= r_s1_v;
            r_done_v <= r_s2_v && r_s2_last;
        end
        r_s1_first   <= (r_k == '0);
        r_s1_last    <= (r_k == r_klast);
        r_s1_final   <= last_issue;
        r_s1_row     <= r_i;
        r_s2_first   <= r_s1_first;
        r_s2_last    <= r_s1_last;
        r_s2_final   <= r_s1_final;
        r_s2_row     <= r_s1_row;
        r_sq         <= 16'(w_sq);
        if (r_s2_v) begin
            r_acc <= w_sum;
        end
        r_dist       <= w_sum;
        r_drow       <= r_s2_row;
        r_done_final <= r_s2_final;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
            r_have2 <= 1'b0;
        end else begin
            r_state <= n_state;

            if (is_match) begin
                r_q     <= PIW'(i_in.row);
                r_na    <= eff_na;
                r_nlast <= PIW'(eff_nb - 1'b1);
                r_klast <= KW'(eff_dims - 1'b1);
                r_best  <= '0;
                r_d1    <= '0;
                r_have2 <= 1'b0;
                r_i     <= '0;
                r_k     <= '0;
            end else if (issue) begin
                if (r_k == r_klast) begin
                    r_k <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end else if (n_state == S_SCANA) begin
                r_i     <= '0;
                r_k     <= '0;
                r_nlast <= PIW'(r_na - 1'b1);
            end

            if (r_done_v) begin
                if (phase_a) begin
                    if ((r_drow == '0) || (r_dist < r_amin)) begin
                        r_amin <= r_dist;
                        r_aidx <= r_drow;
                    end
                end else if ((r_drow == '0) || (r_dist < r_d1)) begin
                    if (r_drow != '0) begin
                        r_d2    <= r_d1;
                        r_have2 <= 1'b1;
                    end
                    r_d1   <= r_dist;
                    r_best <= r_drow;
                end else if ((r_dist > r_d1) && (!r_have2 || (r_dist < r_d2))) begin
                    r_d2    <= r_dist;
                    r_have2 <= 1'b1;
                end
            end

            unique case (r_state)
                S_MULDEN: r_den2 <= 16'(mul_p);
                S_MULNUM: r_num2 <= 16'(mul_p);
                S_MULL:   r_lhs  <= mul_p;
                S_MULR:   r_rhs  <= mul_p;
                default: ;
            endcase

            if ((n_state == S_OUT) && (r_state != S_OUT)) begin
                r_status <= n_status;
            end

            if ((r_state == S_OUT) && out_free) begin
                r_out_v               <= 1'b1;
                r_out.query_index     <= 10'(r_q);
                r_out.partner_index   <= 10'(r_best);
                r_out.status          <= r_status;
                r_out.nearest_dist_sq <= 23'(r_d1);
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    a_drain_before_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done_v && r_done_final |-> !r_s1_v && !r_s2_v)
        else $error("distance pipeline not empty at final row");

    a_second_above_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have2 && (r_state != S_IDLE) |-> r_d2 > r_d1)
        else $error("second distance not above nearest");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_EMPTY)
            |-> (o_out.partner_index == '0) && (o_out.nearest_dist_sq == '0))
        else $error("empty set B result carries data");

    a_no_scan_in_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> !r_s1_v && !r_s2_v && !r_done_v)
        else $error("distance transaction in flight while result is posted");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the descriptor ratio cross-check matcher.
`timescale 1ns / 1ps

module testbench;
    import drcm_pkg::*;

    localparam int ROWS = MAX_POINTS_DEF;
    localparam int DIMS = MAX_DIMS_DEF;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 32;
    localparam int FILL_WIDE = 0;
    localparam int FILL_NARROW = 1;
    localparam int FILL_APART = 2;
    localparam t_cmd CMD_UNUSED = t_cmd'(2'd3);

    typedef struct packed {
        bit                    is_reg;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
        t_in_item              item;
        bit                    typed;
        t_out_item             want;
    } t_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_item              in_bus = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic                  cfg_ready;
    t_out_item             out_bus;

    always #5 i_clk = ~i_clk;

    descriptor_ratio_crosscheck_match_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_bus),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_bus),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bit [7:0]  a_desc [ROWS*DIMS];
    bit [7:0]  b_desc [ROWS*DIMS];
    bit        a_loaded [ROWS*DIMS];
    bit        b_loaded [ROWS*DIMS];
    bit [10:0] m_count_a = 11'd0;
    bit [10:0] m_count_b = 11'd0;
    bit [7:0]  m_dims = 8'd128;
    bit        m_ratio_en = 1'b1;
    bit        m_cross_en = 1'b1;
    bit [7:0]  m_num = 8'd2;
    bit [7:0]  m_den = 8'd5;

    t_out_item pending_matches[$];
    t_step     steps[$];
    int        mismatches = 0;
    int        cycles = 0;
    bit        calm = 1'b0;
    int        hold_request = 0;
    bit        in_held = 1'b0;

    function automatic int unsigned clip_rows(input bit [10:0] c);
        return (c > ROWS) ? ROWS : c;
    endfunction

    function automatic int unsigned live_dims();
        if (m_dims == 0) return 1;
        return (m_dims > DIMS) ? DIMS : m_dims;
    endfunction

    function automatic int unsigned sq_dist(input int unsigned ra, input int unsigned rb,
                                            input int unsigned dims);
        int unsigned acc;
        int diff;
        int k;
        acc = 0;
        for (k = 0; k < dims; k++) begin
            diff = int'(a_desc[ra*DIMS+k]) - int'(b_desc[rb*DIMS+k]);
            acc += diff * diff;
        end
        return acc;
    endfunction

    function automatic t_out_item score_query(input bit [9:0] qrow);
        t_out_item r;
        int unsigned dims, na, nb, best, d1, d2, d, amin, aidx;
        bit have2, found;
        longint unsigned lhs, rhs;
        int i;
        dims = live_dims();
        na = clip_rows(m_count_a);
        nb = clip_rows(m_count_b);
        r = '0;
        r.query_index = qrow;
        if (nb == 0) begin
            r.status = ST_EMPTY;
            return r;
        end
        best = 0;
        d1 = 0;
        d2 = 0;
        have2 = 1'b0;
        for (i = 0; i < nb; i++) begin
            d = sq_dist(qrow, i, dims);
            if (i == 0 || d < d1) begin
                if (i != 0) begin
                    d2 = d1;
                    have2 = 1'b1;
                end
                d1 = d;
                best = i;
            end else if (d > d1 && (!have2 || d < d2)) begin
                d2 = d;
                have2 = 1'b1;
            end
        end
        r.status = ST_OK;
        if (m_ratio_en && have2) begin
            lhs = d1;
            lhs = lhs * m_den * m_den;
            rhs = d2;
            rhs = rhs * m_num * m_num;
            if (lhs > rhs) r.status = ST_RATIO;
        end
        if (r.status == ST_OK && m_cross_en) begin
            found = 1'b0;
            amin = 0;
            aidx = 0;
            for (i = 0; i < na; i++) begin
                d = sq_dist(i, best, dims);
                if (!found || d < amin) begin
                    amin = d;
                    aidx = i;
                    found = 1'b1;
                end
            end
            if (!found || aidx != qrow) r.status = ST_XFAIL;
        end
        r.partner_index = best[9:0];
        r.nearest_dist_sq = d1[22:0];
        return r;
    endfunction

    function automatic void absorb(input t_in_item it, input bit typed, input t_out_item want);
        int unsigned at;
        at = it.row * DIMS + it.col;
        case (it.cmd)
            CMD_LOAD_A: begin
                a_desc[at] = it.value;
                a_loaded[at] = 1'b1;
            end
            CMD_LOAD_B: begin
                b_desc[at] = it.value;
                b_loaded[at] = 1'b1;
            end
            CMD_MATCH: pending_matches.push_back(typed ? want : score_query(it.row));
            default: ;
        endcase
    endfunction

    function automatic t_in_item mk(input t_cmd cmd, input int unsigned row,
                                    input int unsigned col, input int unsigned v);
        t_in_item it;
        it.cmd = cmd;
        it.row = row[9:0];
        it.col = col[6:0];
        it.value = v[7:0];
        return it;
    endfunction

    function automatic t_out_item made_result(input int unsigned q, input int unsigned p,
                                              input t_status st, input int unsigned d);
        t_out_item r;
        r.query_index = q[9:0];
        r.partner_index = p[9:0];
        r.status = st;
        r.nearest_dist_sq = d[22:0];
        return r;
    endfunction

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic [7:0] fill_value(input int fill, input bit for_b);
        case (fill)
            FILL_NARROW: return $urandom_range(0, 3);
            FILL_APART: return for_b ? 8'hFF : 8'h00;
            default: begin
                if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
                return $urandom_range(0, 255);
            end
        endcase
    endfunction

    function automatic void add_reg(input t_cfg_idx idx, input int unsigned data);
        t_step s;
        s = '0;
        s.is_reg = 1'b1;
        s.idx = idx;
        s.data = data[CFG_DATA_W-1:0];
        steps.push_back(s);
    endfunction

    function automatic void add_item(input t_in_item it);
        t_step s;
        s = '0;
        s.item = it;
        steps.push_back(s);
    endfunction

    function automatic void add_check(input t_in_item it, input t_out_item want);
        t_step s;
        s = '0;
        s.item = it;
        s.typed = 1'b1;
        s.want = want;
        steps.push_back(s);
    endfunction

    task automatic push_item(input t_in_item it, input bit typed = 1'b0,
                             input t_out_item want = '0);
        int gap;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_bus <= it;
        do @(posedge i_clk); while (!in_ready);
        in_held = 1'b1;
        absorb(it, typed, want);
    endtask

    task automatic release_in();
        if (in_held) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            in_held = 1'b0;
        end
    endtask

    // Drain all results, then give trailing loads time to land.
    task automatic settle();
        release_in();
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            CFG_COUNT_A:   m_count_a = data;
            CFG_COUNT_B:   m_count_b = data;
            CFG_DIMS_USED: m_dims = data[7:0];
            CFG_RATIO_EN:  m_ratio_en = data[0];
            CFG_CROSS_EN:  m_cross_en = data[0];
            CFG_RATIO_NUM: m_num = data[7:0];
            CFG_RATIO_DEN: m_den = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [10:0] na, input logic [10:0] nb,
                             input logic [7:0] dims, input bit ren, input bit cen,
                             input logic [7:0] num, input logic [7:0] den,
                             input int fill, input int n_items, input int hold);
        int unsigned qmax, lmax, dcount;
        int r, c, k, roll;
        t_cmd lc;
        settle();
        write_reg(CFG_COUNT_A, na);
        write_reg(CFG_COUNT_B, nb);
        write_reg(CFG_DIMS_USED, dims);
        write_reg(CFG_RATIO_EN, ren);
        write_reg(CFG_CROSS_EN, cen);
        write_reg(CFG_RATIO_NUM, num);
        write_reg(CFG_RATIO_DEN, den);
        dcount = live_dims();
        qmax = clip_rows(na) + 1;
        if (qmax > ROWS - 1) qmax = ROWS - 1;
        lmax = (clip_rows(nb) > qmax) ? clip_rows(nb) : qmax;
        if (lmax > ROWS - 1) lmax = ROWS - 1;
        calm = $urandom_range(0, 1);
        // every element a query of this phase can read gets written first
        for (r = 0; r <= qmax; r++)
            for (c = 0; c < dcount; c++)
                if (!a_loaded[r*DIMS+c]) push_item(mk(CMD_LOAD_A, r, c, fill_value(fill, 0)));
        for (r = 0; r < clip_rows(nb); r++)
            for (c = 0; c < dcount; c++)
                if (!b_loaded[r*DIMS+c]) push_item(mk(CMD_LOAD_B, r, c, fill_value(fill, 1)));
        if (hold > 0) hold_request = hold;
        for (k = 0; k < n_items; k++) begin
            if (k == n_items / 2) begin
                settle();
                calm = ~calm;
            end
            roll = $urandom_range(0, 99);
            lc = $urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A;
            if (roll < 55)
                push_item(mk(CMD_MATCH, $urandom_range(0, qmax), 0, 0));
            else if (roll < 92)
                push_item(mk(lc, $urandom_range(0, lmax), $urandom_range(0, dcount - 1),
                             fill_value(fill == FILL_NARROW ? FILL_NARROW : FILL_WIDE, 0)));
            else if (roll < 97)
                push_item(mk(lc, $urandom_range(0, ROWS - 1), $urandom_range(0, DIMS - 1),
                             $urandom_range(0, 255)));
            else
                push_item(mk(CMD_UNUSED, $urandom_range(0, ROWS - 1), $urandom_range(0, DIMS - 1),
                             $urandom_range(0, 255)));
        end
    endtask

    initial begin : result_sink
        int gap;
        t_out_item want;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_gap();
            if (hold_request > 0) begin
                gap = hold_request;
                hold_request = 0;
            end
            @(negedge i_clk);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
            if (pending_matches.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: q=%0d p=%0d st=%0d d=%0d",
                             out_bus.query_index, out_bus.partner_index,
                             out_bus.status, out_bus.nearest_dist_sq);
                mismatches++;
            end else begin
                want = pending_matches.pop_front();
                if (out_bus.query_index !== want.query_index
                        || out_bus.partner_index !== want.partner_index
                        || out_bus.status !== want.status
                        || out_bus.nearest_dist_sq !== want.nearest_dist_sq) begin
                    if (mismatches < 10)
                        $display("mismatch: exp q=%0d p=%0d st=%0d d=%0d, got q=%0d p=%0d st=%0d d=%0d",
                                 want.query_index, want.partner_index, want.status,
                                 want.nearest_dist_sq, out_bus.query_index,
                                 out_bus.partner_index, out_bus.status,
                                 out_bus.nearest_dist_sq);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_reg(CFG_DIMS_USED, 2);
        add_item(mk(CMD_LOAD_A, 0, 0, 0));
        add_item(mk(CMD_LOAD_A, 0, 1, 255));
        add_check(mk(CMD_MATCH, 0, 0, 0), made_result(0, 0, ST_EMPTY, 0));
        add_item(mk(CMD_UNUSED, 1023, 127, 255));
        add_reg(CFG_COUNT_B, 2);
        add_item(mk(CMD_LOAD_B, 0, 0, 0));
        add_item(mk(CMD_LOAD_B, 0, 1, 255));
        add_item(mk(CMD_LOAD_B, 1, 0, 255));
        add_item(mk(CMD_LOAD_B, 1, 1, 0));
        // set A empty: cross-check cannot pass
        add_check(mk(CMD_MATCH, 0, 0, 0), made_result(0, 0, ST_XFAIL, 0));
        add_reg(CFG_COUNT_A, 1);
        add_check(mk(CMD_MATCH, 0, 0, 0), made_result(0, 0, ST_OK, 0));
        // B1 equal to B0: tie, no second distance
        add_item(mk(CMD_LOAD_B, 1, 0, 0));
        add_item(mk(CMD_LOAD_B, 1, 1, 255));
        add_item(mk(CMD_LOAD_A, 1, 0, 0));
        add_item(mk(CMD_LOAD_A, 1, 1, 254));
        add_item(mk(CMD_MATCH, 1, 0, 0));
        add_reg(CFG_COUNT_A, 2);
        add_item(mk(CMD_MATCH, 1, 0, 0));
        add_item(mk(CMD_LOAD_B, 1, 0, 255));
        add_reg(CFG_RATIO_NUM, 0);
        add_item(mk(CMD_MATCH, 0, 0, 0));
        add_item(mk(CMD_MATCH, 1, 0, 0));
        add_reg(CFG_RATIO_DEN, 0);
        add_item(mk(CMD_MATCH, 1, 0, 0));
        add_reg(CFG_RATIO_EN, 0);
        add_reg(CFG_CROSS_EN, 0);
        add_reg(CFG_RATIO_NUM, 255);
        add_reg(CFG_RATIO_DEN, 255);
        add_item(mk(CMD_MATCH, 1, 0, 0));
        add_reg(CFG_DIMS_USED, 0);
        add_item(mk(CMD_MATCH, 1, 0, 0));

        foreach (steps[s]) begin
            if (steps[s].is_reg) begin
                settle();
                write_reg(steps[s].idx, steps[s].data);
            end else begin
                push_item(steps[s].item, steps[s].typed, steps[s].want);
            end
        end

        run_phase(11'd4, 11'd4, 8'd3, 1'b1, 1'b1, 8'd2, 8'd5, FILL_NARROW, 30, 0);
        run_phase(11'd3, 11'd5, 8'd8, 1'b1, 1'b0, 8'd4, 8'd5, FILL_WIDE, 20, 0);
        run_phase(11'd0, 11'd1, 8'd255, 1'b0, 1'b1, 8'd255, 8'd1, FILL_APART, 12, 0);
        run_phase(11'd2047, 11'd2047, 8'd1, 1'b1, 1'b1, 8'd1, 8'd1, FILL_WIDE, 14, 0);
        run_phase(11'd6, 11'd6, 8'd4, 1'b1, 1'b1, 8'd3, 8'd4, FILL_NARROW, 40, 400);
        run_phase(11'd1024, 11'd7, 8'd0, 1'b1, 1'b1, 8'd0, 8'd0, FILL_WIDE, 12, 0);
        run_phase(11'd8, 11'd8, 8'd6, 1'b1, 1'b1, 8'd7, 8'd8, FILL_NARROW, 30, 0);

        settle();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
src/drcm_pkg.sv
src/descriptor_ratio_crosscheck_match_unit.sv
sim/testbench.sv
